/* rtl/bpa_pkg.sv */
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

  // One map word covers this many pages
  localparam int WORD_W = 16;
  localparam int BIT_W  = 4;

  // Field widths of the item channels
  localparam int OP_W       = 2;
  localparam int FIRST_W    = 15;
  localparam int COUNT_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int PAGE_OUT_W = 15;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_t;

  // Result of scanning one map word for a long enough free run
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } scan_hit_t;

endpackage

/* rtl/bpa_map_mem.sv */
// Used-page map storage: one write port, one registered read port.
module bpa_map_mem #(
  parameter int NUM_WORDS = 2048,
  parameter int ADDR_W    = 11
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output bpa_pkg::word_t      rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  bpa_pkg::word_t      wr_data
);
  import bpa_pkg::*;

  word_t mem [NUM_WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bpa_run_scan.sv */
// Free-run search over one map word, continuing a run carried in from lower words.
module bpa_run_scan #(
  parameter int CNT_W = 9
) (
  input  bpa_pkg::word_t       free_bits,
  input  logic [CNT_W-1:0]     run_in,
  input  logic [CNT_W-1:0]     count,
  output bpa_pkg::scan_hit_t   res,
  output logic [CNT_W-1:0]     run_out
);
  import bpa_pkg::*;

  localparam int SUM_W = CNT_W + BIT_W + 1;

  logic [SUM_W-1:0]  run_at [WORD_W];
  logic [WORD_W-1:0] hit_at;

  // Run length ending at each bit: distance to the nearest used bit at or below,
  // or the carried run plus the bits so far when none is used
  always_comb begin
    logic             any_used;
    logic [BIT_W-1:0] last_used;
    any_used  = 1'b0;
    last_used = '0;
    for (int i = 0; i < WORD_W; i++) begin
      any_used  = 1'b0;
      last_used = '0;
      for (int j = 0; j < WORD_W; j++) begin
        if (j <= i && !free_bits[j]) begin
          any_used  = 1'b1;
          last_used = BIT_W'(j);
        end
      end
      if (any_used) begin
        run_at[i] = SUM_W'(i) - SUM_W'(last_used);
      end else begin
        run_at[i] = SUM_W'(run_in) + SUM_W'(i) + SUM_W'(1);
      end
      hit_at[i] = (run_at[i] >= SUM_W'(count));
    end
  end

  // Pick the lowest bit where the run is long enough
  always_comb begin
    res.hit = |hit_at;
    res.pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit_at[i]) begin
        res.pos = BIT_W'(i);
      end
    end
  end

  // Without a hit the run is shorter than count, so it fits
  assign run_out = CNT_W'(run_at[WORD_W-1]);

endmodule

/* rtl/bitmap_page_allocator.sv */
// Top level of the next-fit bitmap page allocator.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | into      | in_valid/in_stall  | opcode, first_page, page_count
//   out     | out of    | out_valid/out_stall| status, alloc_page
//
// Allocate reads map words, one word of 16 pages per cycle on the map's single read
// port (up to two passes of NUM_PAGES/16 words, the second from page zero when the
// search wraps), then marks the found run. Marking reads and rewrites one word per
// cycle over the words the run touches. Free and reserve go straight to that marking
// pass; a bad request goes straight to the response.
// After reset the map is set to all used by a pass over its NUM_PAGES/16 words, with
// in_stall high. One item is worked on at a time; a finished result waits in the
// output register under out_stall while the next item is already accepted.
module bitmap_page_allocator #(
  parameter int NUM_PAGES = 32768,
  parameter int MAX_RUN   = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bpa_pkg::OP_W-1:0]          opcode,
  input  logic [bpa_pkg::FIRST_W-1:0]       first_page,
  input  logic [bpa_pkg::COUNT_W-1:0]       page_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bpa_pkg::STATUS_W-1:0]      status,
  output logic [bpa_pkg::PAGE_OUT_W-1:0]    alloc_page
);
  import bpa_pkg::*;

  localparam int NUM_WORDS = NUM_PAGES / WORD_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int PAGE_W    = WADDR_W + BIT_W;
  localparam int HINT_W    = PAGE_W + 1;
  localparam int CNT_W     = $clog2(MAX_RUN + 1);
  localparam int MR_W      = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;
  localparam int EXT_W     = ((PAGE_W > FIRST_W) ? PAGE_W : FIRST_W) + 1;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  // Control state
  state_t state;
  state_t state_next;
  logic   retry_ok;
  logic   data_valid;

  // Item and search registers
  logic                op_alloc;
  logic                op_set;
  logic [CNT_W-1:0]    count_r;
  logic [PAGE_W-1:0]   lo_page;
  logic [HINT_W-1:0]   hi_page;
  logic [HINT_W-1:0]   hint;
  status_t             status_r;
  logic [WADDR_W:0]    issue_word;
  logic [WADDR_W-1:0]  data_word;
  logic [WADDR_W-1:0]  scan_start_word;
  logic [BIT_W-1:0]    lo_bit;
  logic [CNT_W-1:0]    run;
  logic [WADDR_W-1:0]  clr_word;
  logic [WADDR_W-1:0]  mk_last;

  // Memory ports
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  word_t              rd_data;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  word_t              wr_data;

  // Decoded request and datapath values
  logic               req_bad;
  logic [EXT_W-1:0]   ext_end;
  logic [EXT_W-1:0]   ext_end_m1;
  logic               range_bad;
  logic               hint_ge;
  logic [PAGE_W-1:0]  start_page;
  word_t              start_mask;
  word_t              free_bits;
  scan_hit_t          scan_res;
  logic [CNT_W-1:0]   run_out;
  logic [HINT_W-1:0]  hi_found;
  logic [PAGE_W-1:0]  found_lo;
  word_t              run_mask;
  logic               in_take;
  logic               scan_end;
  logic               load_out;

  // Map word holding a given first page
  function automatic logic [WADDR_W-1:0] first_page_word(input logic [FIRST_W-1:0] pg);
    logic [PAGE_W-1:0] full;
    full = PAGE_W'(pg);
    return full[PAGE_W-1:BIT_W];
  endfunction

  bpa_map_mem #(
    .NUM_WORDS (NUM_WORDS),
    .ADDR_W    (WADDR_W)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bpa_run_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .free_bits (free_bits),
    .run_in    (run),
    .count     (count_r),
    .res       (scan_res),
    .run_out   (run_out)
  );

  // Check the request and the run range of free and reserve
  always_comb begin
    req_bad    = (page_count == '0) || (MR_W'(page_count) > MR_W'(MAX_RUN)) ||
                 !(opcode inside {OP_ALLOC, OP_FREE, OP_RESERVE});
    ext_end    = EXT_W'(first_page) + EXT_W'(page_count);
    ext_end_m1 = ext_end - EXT_W'(1);
    range_bad  = (ext_end > EXT_W'(NUM_PAGES));
  end

  // Search start: a hint at or past the end goes straight to page zero
  always_comb begin
    hint_ge    = (hint >= HINT_W'(NUM_PAGES));
    start_page = hint_ge ? '0 : hint[PAGE_W-1:0];
  end

  // Treat pages below the start as used in the first word of a pass
  always_comb begin
    start_mask = (data_word == scan_start_word) ? (word_t'('1) << lo_bit) : word_t'('1);
    free_bits  = ~rd_data & start_mask;
    hi_found   = {1'b0, data_word, scan_res.pos} + HINT_W'(1);
    found_lo   = PAGE_W'(hi_found - HINT_W'(count_r));
  end

  // Pages of the run inside the word being marked
  always_comb begin
    logic [HINT_W-1:0] p;
    p = '0;
    for (int b = 0; b < WORD_W; b++) begin
      p           = {1'b0, data_word, BIT_W'(b)};
      run_mask[b] = (p >= {1'b0, lo_page}) && (p < hi_page);
    end
  end

  assign in_take  = in_valid && !in_stall;
  assign scan_end = data_valid && !scan_res.hit && (data_word == LAST_WORD);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_word == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (req_bad) begin
            state_next = S_RESP;
          end else if (opcode == OP_ALLOC) begin
            state_next = S_SCAN;
          end else if (range_bad) begin
            state_next = S_RESP;
          end else begin
            state_next = S_MARK;
          end
        end
      end
      S_SCAN: begin
        if (data_valid && scan_res.hit) begin
          state_next = S_MARK;
        end else if (scan_end && !retry_ok) begin
          state_next = S_RESP;
        end
      end
      S_MARK: begin
        if (data_valid && data_word == mk_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the state machine: memory ports, input stall, result load
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = issue_word[WADDR_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = data_word;
    wr_data  = op_set ? (rd_data | run_mask) : (rd_data & ~run_mask);
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_word;
        wr_data = word_t'('1);
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_SCAN: begin
        rd_en = (issue_word < (WADDR_W+1)'(NUM_WORDS)) &&
                !(data_valid && scan_res.hit) && !scan_end;
      end
      S_MARK: begin
        rd_en = (issue_word <= {1'b0, mk_last}) &&
                !(data_valid && data_word == mk_last);
        wr_en = data_valid;
      end
      S_RESP: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_word   <= '0;
      hint       <= '0;
      retry_ok   <= 1'b0;
      data_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      data_valid <= rd_en;
      if (state == S_CLEAR) begin
        clr_word <= clr_word + WADDR_W'(1);
      end
      // Take up the hint at the start of an allocate
      if (state == S_IDLE && in_take && !req_bad && opcode == OP_ALLOC) begin
        retry_ok <= !hint_ge && (hint != '0);
        if (hint_ge) begin
          hint <= '0;
        end
      end
      // Drop back to page zero once, or move the hint past a found run
      if (state == S_SCAN) begin
        if (data_valid && scan_res.hit) begin
          hint <= hi_found;
        end else if (scan_end && retry_ok) begin
          hint     <= '0;
          retry_ok <= 1'b0;
        end
      end
      // Hold the result until the output side takes it
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and search registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_word <= issue_word[WADDR_W-1:0];
    end
    case (state)
      S_IDLE: begin
        if (in_take) begin
          op_alloc        <= (opcode == OP_ALLOC);
          op_set          <= (opcode != OP_FREE);
          count_r         <= CNT_W'(page_count);
          lo_page         <= PAGE_W'(first_page);
          hi_page         <= HINT_W'(ext_end);
          mk_last         <= ext_end_m1[BIT_W +: WADDR_W];
          run             <= '0;
          scan_start_word <= start_page[PAGE_W-1:BIT_W];
          lo_bit          <= start_page[BIT_W-1:0];
          if (req_bad) begin
            status_r <= ST_BAD;
          end else if (opcode == OP_ALLOC) begin
            status_r   <= ST_OK;
            issue_word <= {1'b0, start_page[PAGE_W-1:BIT_W]};
          end else if (range_bad) begin
            status_r <= ST_BAD;
          end else begin
            status_r   <= ST_OK;
            issue_word <= {1'b0, first_page_word(first_page)};
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_word <= issue_word + (WADDR_W+1)'(1);
        end
        if (data_valid) begin
          if (scan_res.hit) begin
            // Found run ends at this bit; mark from its first page
            lo_page    <= found_lo;
            hi_page    <= hi_found;
            mk_last    <= data_word;
            issue_word <= {1'b0, found_lo[PAGE_W-1:BIT_W]};
          end else if (scan_end) begin
            if (retry_ok) begin
              issue_word      <= '0;
              scan_start_word <= '0;
              lo_bit          <= '0;
              run             <= '0;
            end else begin
              status_r <= ST_NO_SPACE;
            end
          end else begin
            run <= run_out;
          end
        end
      end
      S_MARK: begin
        if (rd_en) begin
          issue_word <= issue_word + (WADDR_W+1)'(1);
        end
      end
      default: begin
        op_alloc <= op_alloc;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status <= status_r;
      if (op_alloc && status_r == ST_OK) begin
        alloc_page <= PAGE_OUT_W'(lo_page);
      end else begin
        alloc_page <= '0;
      end
    end
  end

endmodule

/* test/bitmap_page_allocator_tb.sv */
// Self-checking testbench of the next-fit bitmap page allocator.
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NUM_PAGES = 32768;
  localparam int MAX_RUN   = 256;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    status_t                 st;
    logic [PAGE_OUT_W-1:0]   page;
  } page_reply_t;

  typedef struct {
    int first;
    int count;
  } page_run_t;

  // Track the used map and search hint; queue the replies they imply
  class alloc_scoreboard;
    bit          used_bits [0:NUM_PAGES-1];
    int          hint;
    page_reply_t awaited [$];
    int          errors;
    int          n_checked;
    int          n_ok;
    int          n_no_space;
    int          n_bad;

    function new();
      foreach (used_bits[i]) used_bits[i] = 1'b1;
      hint = 0;
      errors = 0;
      n_checked = 0;
      n_ok = 0;
      n_no_space = 0;
      n_bad = 0;
    endfunction

    // Lowest start at or after from with n free pages inside the map, else -1
    function int first_fit_from(int from, int n);
      int run;
      run = 0;
      for (int p = from; p < NUM_PAGES; p++) begin
        if (used_bits[p]) begin
          run = 0;
        end else begin
          run++;
          if (run >= n) return p + 1 - n;
        end
      end
      return -1;
    endfunction

    function void set_run(int first, int n, bit used);
      for (int k = 0; k < n; k++) used_bits[first + k] = used;
    endfunction

    function page_reply_t note_request(logic [OP_W-1:0] op, logic [FIRST_W-1:0] first,
                                       logic [COUNT_W-1:0] count);
      page_reply_t r;
      int          n;
      int          found;
      n = count;
      r.st = ST_OK;
      r.page = '0;
      if (n == 0 || n > MAX_RUN || op > OP_RESERVE) begin
        r.st = ST_BAD;
      end else if (op == OP_ALLOC) begin
        // Search from the hint, then wrap to page zero once
        found = first_fit_from(hint, n);
        if (found < 0 && hint != 0) begin
          hint = 0;
          found = first_fit_from(0, n);
        end
        if (found < 0) begin
          r.st = ST_NO_SPACE;
        end else begin
          set_run(found, n, 1'b1);
          hint = found + n;
          r.page = found[PAGE_OUT_W-1:0];
        end
      end else if (int'(first) + n > NUM_PAGES) begin
        r.st = ST_BAD;
      end else begin
        set_run(first, n, op == OP_RESERVE);
      end
      case (r.st)
        ST_OK:       n_ok++;
        ST_NO_SPACE: n_no_space++;
        default:     n_bad++;
      endcase
      awaited.push_back(r);
      return r;
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [PAGE_OUT_W-1:0] page);
      page_reply_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d alloc_page %0d", st, page);
        errors++;
        return;
      end
      e = awaited.pop_front();
      n_checked++;
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (page !== e.page) begin
        $error("alloc_page: expected %0d, got %0d", e.page, page);
        errors++;
      end
    endfunction

    function int pending_count();
      return awaited.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       opcode;
  logic [FIRST_W-1:0]    first_page;
  logic [COUNT_W-1:0]    page_count;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [PAGE_OUT_W-1:0] alloc_page;

  alloc_scoreboard sb;
  page_run_t       live_runs [$];
  bit              in_gaps;
  bit              out_gaps;

  bitmap_page_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .MAX_RUN   (MAX_RUN)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .first_page (first_page),
    .page_count (page_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .alloc_page (alloc_page)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request, hold it until taken, then predict its reply
  task automatic send_request(logic [OP_W-1:0] op, logic [FIRST_W-1:0] first,
                              logic [COUNT_W-1:0] count);
    int          gap;
    page_reply_t r;
    page_run_t   run;
    if ($urandom_range(0, 31) == 0) in_gaps = ~in_gaps;
    gap = in_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    first_page <= first;
    page_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = sb.note_request(op, first, count);
    if (op == OP_ALLOC && r.st == ST_OK) begin
      run.first = r.page;
      run.count = count;
      live_runs.push_back(run);
    end
  endtask

  // Mostly short runs, some medium, a few up to the largest
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 92) return $urandom_range(17, 96);
    return $urandom_range(97, MAX_RUN);
  endfunction

  task automatic directed_requests();
    send_request(OP_ALLOC, 15'd32767, 9'd1);        // map all used: no space
    send_request(OP_FREE, 15'd0, 9'd256);
    send_request(OP_FREE, 15'd0, 9'd0);             // zero count
    send_request(OP_ALLOC, 15'd0, 9'd257);          // count above the largest run
    send_request(OP_RESERVE, 15'd0, 9'd511);
    send_request(OP_UNUSED, 15'd0, 9'd4);           // unknown opcode
    send_request(OP_FREE, 15'd32767, 9'd2);         // run past the end
    send_request(OP_FREE, 15'd32767, 9'd1);
    send_request(OP_RESERVE, 15'd32512, 9'd256);    // run ending at the last page
    send_request(OP_RESERVE, 15'd32767, 9'd1);      // reserve a used page
    send_request(OP_ALLOC, 15'd0, 9'd100);
    send_request(OP_ALLOC, 15'd0, 9'd200);          // misses from hint and from zero
    send_request(OP_ALLOC, 15'd0, 9'd156);
    send_request(OP_FREE, 15'd100, 9'd56);
    send_request(OP_FREE, 15'd120, 9'd16);          // free already free pages
    send_request(OP_ALLOC, 15'd0, 9'd1);            // wraps to page zero
    send_request(OP_FREE, 15'd32704, 9'd64);
    send_request(OP_ALLOC, 15'd0, 9'd64);           // fills the map tail, hint at end
    send_request(OP_FREE, 15'd0, 9'd8);
    send_request(OP_ALLOC, 15'd0, 9'd8);            // hint past the end
    send_request(OP_ALLOC, 15'd0, 9'd256);
    send_request(OP_FREE, 15'd0, 9'd256);
    send_request(OP_ALLOC, 15'd21845, 9'd256);
    send_request(OP_FREE, 15'd0, 9'd256);
  endtask

  task automatic random_requests(int total);
    int r;
    int n;
    int idx;
    for (int i = 0; i < total; i++) begin
      r = $urandom_range(0, 99);
      if (i < 12) begin
        // Open up scattered free regions first
        n = $urandom_range(128, MAX_RUN);
        send_request(OP_FREE, 15'($urandom_range(0, NUM_PAGES - n)), 9'(n));
      end else if (r < 38) begin
        send_request(OP_ALLOC, 15'($urandom), 9'(pick_count()));
      end else if (r < 62) begin
        // Release a run handed out earlier, or an arbitrary region
        if (live_runs.size() > 0 && $urandom_range(0, 2) != 0) begin
          idx = $urandom_range(0, live_runs.size() - 1);
          send_request(OP_FREE, 15'(live_runs[idx].first), 9'(live_runs[idx].count));
          live_runs.delete(idx);
        end else begin
          n = pick_count();
          send_request(OP_FREE, 15'($urandom_range(0, NUM_PAGES - n)), 9'(n));
        end
      end else if (r < 74) begin
        n = pick_count();
        send_request(OP_RESERVE, 15'($urandom_range(0, NUM_PAGES - n)), 9'(n));
      end else if (r < 82) begin
        n = $urandom_range(2, MAX_RUN);
        send_request($urandom_range(0, 1) ? OP_FREE : OP_RESERVE,
                     15'($urandom_range(NUM_PAGES - n + 1, NUM_PAGES - 1)), 9'(n));
      end else begin
        case ($urandom_range(0, 2))
          0:       send_request(2'($urandom), 15'($urandom), 9'd0);
          1:       send_request(2'($urandom), 15'($urandom),
                                9'($urandom_range(MAX_RUN + 1, 511)));
          default: send_request(OP_UNUSED, 15'($urandom), 9'(pick_count()));
        endcase
      end
    end
  endtask

  // Drive requests and finish the run
  initial begin
    sb = new();
    in_gaps = 1'b1;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    opcode     <= OP_ALLOC;
    first_page <= '0;
    page_count <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    directed_requests();
    random_requests(266);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Checked %0d replies: %0d ok, %0d no space, %0d bad request,",
             sb.n_checked, sb.n_ok, sb.n_no_space, sb.n_bad);
    $display("with idle gaps and stalls on both channels.");
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("bitmap_page_allocator test passed");
    end else begin
      $display("bitmap_page_allocator test failed");
    end
    $finish;
  end

  // Take replies with random stalls and check each one
  initial begin
    int n;
    out_gaps = 1'b1;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 31) == 0) out_gaps = ~out_gaps;
      n = out_gaps ? $urandom_range(0, 10) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_response(status, alloc_page);
    end
  end

  // Stop a hung run
  initial begin
    #50_000_000;
    $display("bitmap_page_allocator test failed");
    $finish;
  end

endmodule

/* bitmap_page_allocator.f */
rtl/bpa_pkg.sv
rtl/bpa_map_mem.sv
rtl/bpa_run_scan.sv
rtl/bitmap_page_allocator.sv
test/bitmap_page_allocator_tb.sv
